>>> design/assert_macros.svh
// Concurrent assertion helpers for the span table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSST_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CSST_ASSERT(label, clk, rst_n, prop, msg)
`define CSST_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> design/csst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csst_pkg;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [15:0] EMPTY_SPAN = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WALK,
        ST_FINISH
    } csst_state_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic walk;
        logic push;
    } csst_ctl_t;

    typedef struct packed {
        logic sweep_last;
        logic walk_last;
        logic out_free;
    } csst_stat_t;

endpackage

`default_nettype wire

>>> design/csst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csst_cmd_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic signed [9:0] center_x;
    logic signed [9:0] center_y;
    logic [8:0]        radius;
    logic [7:0]        line;

    modport source (output valid, output opcode, output center_x, output center_y,
                    output radius, output line, input ready);
    modport sink   (input valid, input opcode, input center_x, input center_y,
                    input radius, input line, output ready);
endinterface

interface csst_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] span_value;
    logic [8:0]  word_offset;
    logic        draw_done;

    modport source (output valid, output span_value, output word_offset,
                    output draw_done, input ready);
    modport sink   (input valid, input span_value, input word_offset,
                    input draw_done, output ready);
endinterface

`default_nettype wire

>>> design/csst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_ctrl
    import csst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       opcode,
    input  csst_stat_t stat,
    output logic       cmd_ready,
    output csst_ctl_t  ctl
);

    csst_state_t state_reg;
    csst_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (opcode == OP_READ) ? ST_FINISH : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.load  = cmd_valid;
            end
            ST_SWEEP:
            begin
                ctl.sweep = 1'b1;
            end
            ST_WALK:
            begin
                ctl.walk = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.push = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/csst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_datapath
    import csst_pkg::*;
#(
    parameter int LINES        = 160,
    parameter int SCREEN_WIDTH = 240
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              opcode,
    input  logic signed [9:0] center_x,
    input  logic signed [9:0] center_y,
    input  logic [8:0]        radius,
    input  logic [7:0]        line,
    input  csst_ctl_t         ctl,
    output csst_stat_t        stat,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [15:0]       span_value,
    output logic [8:0]        word_offset,
    output logic              draw_done
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(LINES - 1);
    localparam logic signed [11:0] ROW_LIM   = 12'(LINES);
    localparam logic [8:0]        LINE_LIM   = 9'(LINES);
    localparam logic signed [11:0] X_MAX     = 12'(SCREEN_WIDTH - 1);
    localparam logic [7:0]        X_MAX8     = 8'(SCREEN_WIDTH - 1);
    localparam logic [1:0]        LAST_PHASE = 2'd3;

    function automatic logic [7:0] clamp_x(input logic signed [11:0] v);
        if (v[11])
        begin
            return 8'd0;
        end
        else if (v > X_MAX)
        begin
            return X_MAX8;
        end
        return v[7:0];
    endfunction

    logic [15:0] span_mem [LINES];
    logic [15:0] rd_data_reg;

    logic               stride_reg,    stride_next;
    logic [LINES-1:0]   valid_reg,     valid_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [15:0]        rsp_span_reg,  rsp_span_next;
    logic [8:0]         rsp_off_reg,   rsp_off_next;
    logic               rsp_done_reg,  rsp_done_next;
    logic               is_read_reg,   is_read_next;
    logic               hit_reg,       hit_next;
    logic [8:0]         off_reg,       off_next;
    logic signed [9:0]  cx_reg,        cx_next;
    logic signed [9:0]  cy_reg,        cy_next;
    logic signed [10:0] lo_reg,        lo_next;
    logic signed [10:0] hi_reg,        hi_next;
    logic signed [10:0] x_reg,         x_next;
    logic signed [10:0] y_reg,         y_next;
    logic signed [14:0] d_reg,         d_next;
    logic [1:0]         phase_reg,     phase_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;

    logic signed [11:0] cx_ext;
    logic signed [11:0] cy_ext;
    logic signed [11:0] half_ext;
    logic signed [11:0] off_ext;
    logic signed [11:0] row;
    logic               row_ok;
    logic               wr_en;
    logic [IDX_W-1:0]   waddr;
    logic [15:0]        span_w;
    logic               d_pos;
    logic signed [10:0] x_upd;
    logic signed [10:0] y_upd;
    logic signed [14:0] x4;
    logic signed [14:0] y4;
    logic signed [14:0] d_upd;
    logic signed [11:0] i_ext;
    logic               sweep_clear;
    logic               line_ok;
    logic               rd_en;
    logic [IDX_W-1:0]   raddr;
    logic               out_free;

    assign cx_ext   = {{2{cx_reg[9]}}, cx_reg};
    assign cy_ext   = {{2{cy_reg[9]}}, cy_reg};
    assign half_ext = phase_reg[1] ? {x_reg[10], x_reg} : {y_reg[10], y_reg};
    assign off_ext  = phase_reg[1] ? {y_reg[10], y_reg} : {x_reg[10], x_reg};
    assign row      = phase_reg[0] ? (cy_ext - off_ext) : (cy_ext + off_ext);
    assign row_ok   = !row[11] && (row < ROW_LIM);
    assign wr_en    = ctl.walk && row_ok;
    assign waddr    = row[IDX_W-1:0];
    assign span_w   = {clamp_x(cx_ext - half_ext), clamp_x(cx_ext + half_ext)};

    assign d_pos = !d_reg[14];
    assign y_upd = d_pos ? (y_reg - 11'sd1) : y_reg;
    assign x_upd = x_reg + 11'sd1;
    assign y4    = {{2{y_upd[10]}}, y_upd, 2'b00};
    assign x4    = {{2{x_upd[10]}}, x_upd, 2'b00};
    assign d_upd = d_reg - (d_pos ? y4 : 15'sd0) + x4 + 15'sd2;

    assign i_ext       = {{(12 - IDX_W){1'b0}}, idx_reg};
    assign sweep_clear = (i_ext < $signed({lo_reg[10], lo_reg}))
                      || (i_ext > $signed({hi_reg[10], hi_reg}));

    assign line_ok = ({1'b0, line} < LINE_LIM);
    assign rd_en   = ctl.load && (opcode == OP_READ) && line_ok;
    assign raddr   = line[IDX_W-1:0];

    assign out_free        = !rsp_valid_reg || rsp_ready;
    assign stat.sweep_last = (idx_reg == LAST_IDX);
    assign stat.walk_last  = (phase_reg == LAST_PHASE) && (y_upd < x_upd);
    assign stat.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            span_mem[waddr] <= span_w;
        end
        if (rd_en)
        begin
            rd_data_reg <= span_mem[raddr];
        end
    end

    always_comb
    begin
        stride_next    = cfg_we ? cfg_wdata : stride_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_span_next  = rsp_span_reg;
        rsp_off_next   = rsp_off_reg;
        rsp_done_next  = rsp_done_reg;
        is_read_next   = is_read_reg;
        hit_next       = hit_reg;
        off_next       = off_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        d_next         = d_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;

        if (ctl.load)
        begin
            is_read_next = (opcode == OP_READ);
            hit_next     = line_ok && valid_reg[raddr];
            off_next     = stride_reg ? {line, 1'b0} : {1'b0, line};
            cx_next      = center_x;
            cy_next      = center_y;
            lo_next      = {center_y[9], center_y} - {2'b00, radius};
            hi_next      = {center_y[9], center_y} + {2'b00, radius};
            x_next       = 11'sd0;
            y_next       = {2'b00, radius};
            d_next       = 15'sd3 - {5'b00000, radius, 1'b0};
            phase_next   = 2'd0;
            idx_next     = '0;
        end

        if (ctl.sweep)
        begin
            if (sweep_clear)
            begin
                valid_next[idx_reg] = 1'b0;
            end
            idx_next = idx_reg + 1'b1;
        end

        if (ctl.walk)
        begin
            if (wr_en)
            begin
                valid_next[waddr] = 1'b1;
            end
            phase_next = phase_reg + 2'd1;
            if (phase_reg == LAST_PHASE)
            begin
                x_next = x_upd;
                y_next = y_upd;
                d_next = d_upd;
            end
        end

        if (ctl.push)
        begin
            rsp_valid_next = 1'b1;
            rsp_span_next  = is_read_reg ? (hit_reg ? rd_data_reg : EMPTY_SPAN) : 16'h0000;
            rsp_off_next   = is_read_reg ? off_reg : 9'd0;
            rsp_done_next  = !is_read_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            stride_reg    <= stride_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_span_reg <= rsp_span_next;
        rsp_off_reg  <= rsp_off_next;
        rsp_done_reg <= rsp_done_next;
        is_read_reg  <= is_read_next;
        hit_reg      <= hit_next;
        off_reg      <= off_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        d_reg        <= d_next;
        phase_reg    <= phase_next;
        idx_reg      <= idx_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign span_value  = rsp_span_reg;
    assign word_offset = rsp_off_reg;
    assign draw_done   = rsp_done_reg;

endmodule

`default_nettype wire

>>> design/circle_scanline_span_table.sv
// Circle scanline span table.
// Commands arrive on the cmd channel (valid/ready); a beat is either a draw
// (center and radius) or a read of one scanline. Every command beat yields
// exactly one result beat on the rsp channel: a read returns the line's span
// (0xFFFF when empty) and its word offset, a draw returns draw_done set.
// The user writes stride_log2 through cfg_we/cfg_wdata while the block is
// idle; the block itself does not enforce this. A read result is loaded into
// the output register from the finish state once that register is free. A
// draw result follows an empty sweep over every table line, then about
// N = floor(radius/sqrt(2)) + 1 midpoint steps, each writing the four rows it
// touches one at a time, as the table has a single write port.
// Commands are taken one at a time; the next one is accepted the cycle after
// the previous result is loaded into the output register.
// Reset clears the per-line valid bits, so every line reads as empty at once,
// and clears stride_log2 and the output register's valid bit.
// When the receiver stalls, the pending result holds in the output register;
// the block still accepts and works on one more command and then waits
// until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module circle_scanline_span_table
    import csst_pkg::*;
#(
    parameter int LINES        = 160,
    parameter int SCREEN_WIDTH = 240
)
(
    input  logic              clk,
    input  logic              rst_n,
    csst_cmd_if.sink          cmd,
    csst_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    csst_ctl_t  ctl;
    csst_stat_t stat;
    logic       cmd_ready;

    assign cmd.ready = cmd_ready;

    csst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .opcode    (cmd.opcode),
        .stat      (stat),
        .cmd_ready (cmd_ready),
        .ctl       (ctl)
    );

    csst_datapath #(
        .LINES        (LINES),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .opcode      (cmd.opcode),
        .center_x    (cmd.center_x),
        .center_y    (cmd.center_y),
        .radius      (cmd.radius),
        .line        (cmd.line),
        .ctl         (ctl),
        .stat        (stat),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .span_value  (rsp.span_value),
        .word_offset (rsp.word_offset),
        .draw_done   (rsp.draw_done)
    );

    `CSST_ASSERT(a_one_cmd_in_flight, clk, rst_n, (cmd.valid && cmd.ready) |=> !cmd.ready, "command accepted while busy")
    `CSST_ASSERT(a_draw_ack_zero, clk, rst_n, (rsp.valid && rsp.draw_done) |-> (rsp.span_value == 16'h0000 && rsp.word_offset == 9'd0), "draw result carries data")
    `CSST_ASSERT(a_span_ordered, clk, rst_n, (rsp.valid && !rsp.draw_done && rsp.span_value != EMPTY_SPAN) |-> (rsp.span_value[15:8] <= rsp.span_value[7:0] && rsp.span_value[7:0] <= 8'(SCREEN_WIDTH - 1)), "span limits out of order")
    `CSST_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, ctl.push && rsp.valid && !rsp.ready, "result overwrites a pending beat")

endmodule

`default_nettype wire
